/* rtl/core/cfh_pkg.sv */
// shared types, constants and the fnv-1a step for the container checker
// no dependencies; the config interface, core, verdict, top level and testbench use this package
`default_nettype none

package cfh_pkg;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  // register indexes on the config channel
  localparam logic [CFG_IDX_W-1:0] CFG_EXP_VERSION = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VERIFY      = 2'd1;

  // header is magic (8) + version (4) + size (8) + checksum (8)
  localparam logic [4:0] HDR_LEN  = 5'd28;
  localparam logic [4:0] HDR_LAST = 5'd27;
  localparam logic [4:0] VER_POS  = 5'd8;
  localparam logic [4:0] SIZE_POS = 5'd12;

  localparam logic [63:0] FNV_BASIS = 64'hCBF2_9CE4_8422_2325;

  // "OSGCOOK" followed by a zero byte
  localparam logic [7:0] MAGIC [8] = '{8'h4F, 8'h53, 8'h47, 8'h43,
                                       8'h4F, 8'h4F, 8'h4B, 8'h00};

  typedef enum logic [2:0] {
    ST_OK            = 3'd0,
    ST_SHORT_HDR     = 3'd1,
    ST_BAD_MAGIC     = 3'd2,
    ST_BAD_VERSION   = 3'd3,
    ST_SHORT_PAYLOAD = 3'd4,
    ST_SIZE_MISMATCH = 3'd5,
    ST_CSUM_MISMATCH = 3'd6
  } cfh_status_e;

  // file state captured on the last byte, handed to the checking stage
  typedef struct packed {
    logic        short_hdr;
    logic        magic_ok;
    logic [31:0] version;
    logic [63:0] declared_size;
    logic [63:0] stored_checksum;
    logic [63:0] hash;
    logic [63:0] plen;
  } cfh_snap_t;

  // one fnv-1a round; prime 0x100000001b3 is sparse, so shifts and adds
  function automatic logic [63:0] fnv_step(input logic [63:0] h, input logic [7:0] b);
    logic [63:0] x;
    x = h ^ {56'd0, b};
    return x + (x << 1) + (x << 4) + (x << 5) + (x << 7) + (x << 8) + (x << 40);
  endfunction

endpackage

`default_nettype wire

/* rtl/core/cfh_in_if.sv */
// byte stream channel: one file byte and its last-byte flag per transfer
// no dependencies
`default_nettype none

interface cfh_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic       last_byte;

  modport source (output valid, output byte_value, output last_byte, input ready);
  modport sink   (input valid, input byte_value, input last_byte, output ready);
endinterface

`default_nettype wire

/* rtl/core/cfh_out_if.sv */
// result channel: status, payload hash and payload length per file
// no dependencies
`default_nettype none

interface cfh_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [63:0] payload_hash;
  logic [63:0] payload_length;

  modport source (output valid, output status, output payload_hash,
                  output payload_length, input ready);
  modport sink   (input valid, input status, input payload_hash,
                  input payload_length, output ready);
endinterface

`default_nettype wire

/* rtl/core/cfh_cfg_if.sv */
// register write channel: index and data per transfer
// depends on cfh_pkg for the index and data widths
`default_nettype none

interface cfh_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [cfh_pkg::CFG_IDX_W-1:0]  index;
  logic [cfh_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* rtl/core/cfh_core.sv */
// input register and per-byte state update: header capture, fnv-1a hash,
// byte and payload counters; snapshots the file state on the last byte
// depends on cfh_pkg and cfh_in_if
`default_nettype none

module cfh_core (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  cfh_in_if.sink                 in_if,
  input  wire logic              snap_take_i,
  output logic                   snap_vld_o,
  output cfh_pkg::cfh_snap_t     snap_o
);
  import cfh_pkg::*;

  logic        in_vld_q;
  logic [7:0]  in_byte_q;
  logic        in_last_q;

  logic [63:0] count_q, count_d, count_upd;
  logic [63:0] plen_q, plen_d, plen_upd;
  logic [63:0] hash_q, hash_d, hash_upd;
  logic        magic_q, magic_d, magic_upd;
  logic [31:0] ver_q, ver_d, ver_upd;
  logic [63:0] size_q, size_d, size_upd;
  logic [63:0] csum_q, csum_d, csum_upd;

  logic        snap_vld_q;
  cfh_snap_t   snap_q;

  logic        go;
  logic [4:0]  pos_lo;
  logic        in_hdr;
  logic        count_max;
  logic [2:0]  lane;

  // a last byte waits until the snapshot slot is free
  assign go          = in_vld_q && (!in_last_q || !snap_vld_q || snap_take_i);
  assign in_if.ready = !in_vld_q || go;

  assign pos_lo    = count_q[4:0];
  assign in_hdr    = (count_q[63:5] == '0) && (pos_lo < HDR_LEN);
  assign count_max = &count_q;
  // size and checksum bytes both start at a position with low bits 100
  assign lane      = pos_lo[2:0] - 3'd4;

  always_comb begin
    count_upd = count_q;
    plen_upd  = plen_q;
    hash_upd  = hash_q;
    magic_upd = magic_q;
    ver_upd   = ver_q;
    size_upd  = size_q;
    csum_upd  = csum_q;

    if (in_hdr) begin
      if (pos_lo < VER_POS) begin
        if (in_byte_q != MAGIC[pos_lo[2:0]]) begin
          magic_upd = 1'b0;
        end
      end else if (pos_lo < SIZE_POS) begin
        ver_upd[{pos_lo[1:0], 3'b000} +: 8] = in_byte_q;
      end else if (pos_lo[4:3] == 2'b01 || pos_lo == 5'd16 || pos_lo[4:2] == 3'b100) begin
        // positions 12..19
        size_upd[{lane, 3'b000} +: 8] = in_byte_q;
      end else begin
        csum_upd[{lane, 3'b000} +: 8] = in_byte_q;
      end
    end else begin
      hash_upd = fnv_step(hash_q, in_byte_q);
      if (!count_max) begin
        plen_upd = plen_q + 64'd1;
      end
    end

    if (!count_max) begin
      count_upd = count_q + 64'd1;
    end
  end

  always_comb begin
    count_d = count_q;
    plen_d  = plen_q;
    hash_d  = hash_q;
    magic_d = magic_q;
    ver_d   = ver_q;
    size_d  = size_q;
    csum_d  = csum_q;
    if (go) begin
      if (in_last_q) begin
        count_d = '0;
        plen_d  = '0;
        hash_d  = FNV_BASIS;
        magic_d = 1'b1;
        ver_d   = '0;
        size_d  = '0;
        csum_d  = '0;
      end else begin
        count_d = count_upd;
        plen_d  = plen_upd;
        hash_d  = hash_upd;
        magic_d = magic_upd;
        ver_d   = ver_upd;
        size_d  = size_upd;
        csum_d  = csum_upd;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q   <= 1'b0;
      snap_vld_q <= 1'b0;
      count_q    <= '0;
      plen_q     <= '0;
      hash_q     <= FNV_BASIS;
      magic_q    <= 1'b1;
      ver_q      <= '0;
      size_q     <= '0;
      csum_q     <= '0;
    end else begin
      if (in_if.ready) begin
        in_vld_q <= in_if.valid;
      end
      if (go && in_last_q) begin
        snap_vld_q <= 1'b1;
      end else if (snap_take_i) begin
        snap_vld_q <= 1'b0;
      end
      count_q <= count_d;
      plen_q  <= plen_d;
      hash_q  <= hash_d;
      magic_q <= magic_d;
      ver_q   <= ver_d;
      size_q  <= size_d;
      csum_q  <= csum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_if.valid && in_if.ready) begin
      in_byte_q <= in_if.byte_value;
      in_last_q <= in_if.last_byte;
    end
    if (go && in_last_q) begin
      // fewer than 28 bytes unless this byte was header position 27
      snap_q.short_hdr       <= in_hdr && (pos_lo != HDR_LAST);
      snap_q.magic_ok        <= magic_upd;
      snap_q.version         <= ver_upd;
      snap_q.declared_size   <= size_upd;
      snap_q.stored_checksum <= csum_upd;
      snap_q.hash            <= hash_upd;
      snap_q.plen            <= plen_upd;
    end
  end

  assign snap_vld_o = snap_vld_q;
  assign snap_o     = snap_q;

endmodule

`default_nettype wire

/* rtl/core/cfh_verdict.sv */
// config registers and the status decision, with the result register
// depends on cfh_pkg, cfh_cfg_if and cfh_out_if
`default_nettype none

module cfh_verdict (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  cfh_cfg_if.sink                cfg_if,
  input  wire logic              snap_vld_i,
  input  wire cfh_pkg::cfh_snap_t snap_i,
  output logic                   snap_take_o,
  cfh_out_if.source              out_if
);
  import cfh_pkg::*;

  logic [31:0] exp_ver_q;
  logic        verify_q;

  logic        out_vld_q;
  cfh_status_e out_status_q;
  logic [63:0] out_hash_q;
  logic [63:0] out_len_q;

  cfh_status_e status_d;
  logic        out_free;

  assign cfg_if.ready = 1'b1;

  assign out_free    = !out_vld_q || out_if.ready;
  assign snap_take_o = out_free;

  always_comb begin
    if (snap_i.short_hdr) begin
      status_d = ST_SHORT_HDR;
    end else if (!snap_i.magic_ok) begin
      status_d = ST_BAD_MAGIC;
    end else if (snap_i.version != exp_ver_q) begin
      status_d = ST_BAD_VERSION;
    end else if (snap_i.declared_size > snap_i.plen) begin
      status_d = ST_SHORT_PAYLOAD;
    end else if (snap_i.declared_size != snap_i.plen) begin
      status_d = ST_SIZE_MISMATCH;
    end else if (verify_q && (snap_i.hash != snap_i.stored_checksum)) begin
      status_d = ST_CSUM_MISMATCH;
    end else begin
      status_d = ST_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_ver_q <= '0;
      verify_q  <= 1'b1;
      out_vld_q <= 1'b0;
    end else begin
      if (cfg_if.valid) begin
        case (cfg_if.index)
          CFG_EXP_VERSION: exp_ver_q <= cfg_if.data;
          CFG_VERIFY:      verify_q  <= cfg_if.data[0];
          default: ;
        endcase
      end
      if (out_free) begin
        out_vld_q <= snap_vld_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && snap_vld_i) begin
      out_status_q <= status_d;
      out_hash_q   <= snap_i.hash;
      out_len_q    <= snap_i.plen;
    end
  end

  assign out_if.valid          = out_vld_q;
  assign out_if.status         = out_status_q;
  assign out_if.payload_hash   = out_hash_q;
  assign out_if.payload_length = out_len_q;

endmodule

`default_nettype wire

/* rtl/core/cooked_file_header_and_fnv_check.sv */
// checked container validator, one file byte per cycle unless a result waits behind a stalled output
// a result passes the input register, the state update with snapshot and
// the status register after the last byte's transfer
// throughput: one byte per cycle while no result waits behind a stalled output
// reset: config goes to version 0 with checking on, stream state is cleared,
// and the stream state clears again after every last byte
`default_nettype none

module cooked_file_header_and_fnv_check (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  cfh_cfg_if.sink    cfg_if,
  cfh_in_if.sink     in_if,
  cfh_out_if.source  out_if
);
  import cfh_pkg::*;

  logic      snap_vld;
  logic      snap_take;
  cfh_snap_t snap;

  cfh_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_if       (in_if),
    .snap_take_i (snap_take),
    .snap_vld_o  (snap_vld),
    .snap_o      (snap)
  );

  cfh_verdict u_verdict (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_if      (cfg_if),
    .snap_vld_i  (snap_vld),
    .snap_i      (snap),
    .snap_take_o (snap_take),
    .out_if      (out_if)
  );

  // a short file reports an empty payload and the untouched hash
  a_short_hdr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && (out_if.status == ST_SHORT_HDR) |->
      (out_if.payload_length == '0) && (out_if.payload_hash == FNV_BASIS))
    else $error("short header result carries payload data");

  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid |-> (out_if.status <= ST_CSUM_MISMATCH))
    else $error("status code out of range");

  // input only stalls when a result is waiting behind a stalled output
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_if.ready |-> out_if.valid && !out_if.ready && snap_vld)
    else $error("input stalled without output backpressure");

endmodule

`default_nettype wire

/* tb/testbench.sv */
// testbench for the container validator: directed files from a table, then random files
// depends on cfh_pkg, the three channel interfaces and the validator top level
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import cfh_pkg::*;

  localparam logic [63:0] OFFSET_BASIS = 64'hCBF2_9CE4_8422_2325;
  localparam logic [63:0] FNV_PRIME64  = 64'h0000_0100_0000_01B3;
  localparam logic [63:0] HEADER_BYTES = 64'd28;
  localparam logic [4:0]  NO_FLIP      = 5'd31;
  localparam int          RAND_BYTES   = 750;
  localparam int          RAND_FILES   = 15;
  localparam int          DRAIN_CYCLES = 6;

  // indexes above the register file, writes there must be dropped
  localparam logic [1:0] CFG_SPARE_A = 2'd2;
  localparam logic [1:0] CFG_SPARE_B = 2'd3;

  localparam logic [7:0] HDR_MAGIC [8] = '{"O", "S", "G", "C", "O", "O", "K", 8'h00};

  typedef struct packed {
    cfh_status_e status;
    logic [63:0] hash;
    logic [63:0] length;
  } file_verdict_t;

  typedef struct packed {
    logic [63:0] count;
    logic [63:0] hash;
    logic        magic_ok;
    logic [31:0] version;
    logic [63:0] dsize;
    logic [63:0] csum;
  } stream_t;

  // one directed file; typed rows expect the status with an empty payload
  typedef struct packed {
    logic        set_cfg;
    logic [31:0] cfg_ver;
    logic [31:0] cfg_verify;
    logic [4:0]  take;
    logic [4:0]  flip_at;
    logic [31:0] ver;
    logic [63:0] dsize;
    logic        good_csum;
    logic [63:0] csum;
    logic [7:0]  plen;
    logic        typed;
    cfh_status_e st;
  } file_row_t;

  localparam int NUM_ROWS = 15;
  localparam file_row_t FILE_ROWS [NUM_ROWS] = '{
    '{1'b0, 32'h0, 32'h0, 5'd1, 5'd0, 32'h0, 64'h0, 1'b0, 64'h0, 8'd0, 1'b1, ST_SHORT_HDR},
    '{1'b0, 32'h0, 32'h0, 5'd27, NO_FLIP, 32'h0, 64'h0, 1'b0, 64'h0, 8'd0, 1'b1, ST_SHORT_HDR},
    '{1'b0, 32'h0, 32'h0, 5'd28, 5'd7, 32'h0, 64'h0, 1'b0, 64'h0, 8'd0, 1'b1, ST_BAD_MAGIC},
    '{1'b0, 32'h0, 32'h0, 5'd28, NO_FLIP, 32'h5, 64'h0, 1'b0, 64'h0, 8'd0, 1'b1,
      ST_BAD_VERSION},
    '{1'b0, 32'h0, 32'h0, 5'd28, NO_FLIP, 32'h0, 64'h1, 1'b0, 64'h0, 8'd0, 1'b1,
      ST_SHORT_PAYLOAD},
    '{1'b0, 32'h0, 32'h0, 5'd28, NO_FLIP, 32'h0, '1, 1'b0, 64'h0, 8'd2, 1'b0, ST_OK},
    '{1'b0, 32'h0, 32'h0, 5'd28, NO_FLIP, 32'h0, 64'h0, 1'b0, 64'h0, 8'd1, 1'b0, ST_OK},
    '{1'b0, 32'h0, 32'h0, 5'd28, NO_FLIP, 32'h0, 64'h0, 1'b0, 64'h0, 8'd0, 1'b1,
      ST_CSUM_MISMATCH},
    '{1'b0, 32'h0, 32'h0, 5'd28, NO_FLIP, 32'h0, 64'h0, 1'b0, OFFSET_BASIS, 8'd0, 1'b1, ST_OK},
    '{1'b0, 32'h0, 32'h0, 5'd28, NO_FLIP, 32'h0, 64'h3, 1'b1, 64'h0, 8'd3, 1'b0, ST_OK},
    '{1'b0, 32'h0, 32'h0, 5'd28, NO_FLIP, 32'h0, 64'h2, 1'b1, 64'h8000_0000_0000_0000, 8'd2,
      1'b0, ST_OK},
    // checking off, version at its top
    '{1'b1, '1, 32'hFFFF_FFFE, 5'd28, NO_FLIP, '1, 64'h0, 1'b0, 64'h0, 8'd0, 1'b1, ST_OK},
    '{1'b0, 32'h0, 32'h0, 5'd28, NO_FLIP, 32'h0, 64'h0, 1'b0, 64'h0, 8'd0, 1'b1,
      ST_BAD_VERSION},
    '{1'b0, 32'h0, 32'h0, 5'd28, NO_FLIP, '1, 64'h1, 1'b0, '1, 8'd1, 1'b0, ST_OK},
    // bad magic wins over bad version
    '{1'b1, 32'h0, 32'h0000_0001, 5'd28, 5'd0, 32'h5, 64'h0, 1'b0, 64'h0, 8'd0, 1'b1,
      ST_BAD_MAGIC}
  };

  logic clk_i;
  logic rst_ni;

  cfh_cfg_if cfg_bus ();
  cfh_in_if  byte_bus ();
  cfh_out_if result_bus ();

  cooked_file_header_and_fnv_check DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_if (cfg_bus),
    .in_if  (byte_bus),
    .out_if (result_bus)
  );

  stream_t       strm;
  logic [31:0]   cfg_version;
  logic          cfg_verify;
  file_verdict_t file_verdicts [$];
  int            errors = 0;
  int            bytes_sent = 0;
  int            tx_idle_pct = 19;
  int            rx_idle_pct = 54;

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  always @(posedge clk_i) begin
    result_bus.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
  end

  function automatic logic [63:0] fnv_round(input logic [63:0] h, input logic [7:0] b);
    return (h ^ {56'd0, b}) * FNV_PRIME64;
  endfunction

  function automatic void restart_stream();
    strm.count    = '0;
    strm.hash     = OFFSET_BASIS;
    strm.magic_ok = 1'b1;
    strm.version  = '0;
    strm.dsize    = '0;
    strm.csum     = '0;
  endfunction

  // queue a verdict at the tail, in file order
  function automatic void queue_verdict(input file_verdict_t v);
    file_verdicts.insert(file_verdicts.size(), v);
  endfunction

  // advance the stream by one byte; returns 1 with the verdict on the last byte
  function automatic bit fold_byte(input logic [7:0] b, input logic last,
                                   output file_verdict_t v);
    logic [63:0] plen;
    int unsigned p;
    v = '0;
    if (strm.count < HEADER_BYTES) begin
      p = int'(strm.count[4:0]);
      if (p < 8) begin
        if (b != HDR_MAGIC[p]) strm.magic_ok = 1'b0;
      end else if (p < 12) begin
        strm.version[8*(p-8) +: 8] = b;
      end else if (p < 20) begin
        strm.dsize[8*(p-12) +: 8] = b;
      end else begin
        strm.csum[8*(p-20) +: 8] = b;
      end
    end else begin
      strm.hash = fnv_round(strm.hash, b);
    end
    // counter saturates at all ones
    if (strm.count != '1) strm.count = strm.count + 64'd1;
    if (!last) return 1'b0;
    plen = (strm.count >= HEADER_BYTES) ? strm.count - HEADER_BYTES : '0;
    if (strm.count < HEADER_BYTES) v.status = ST_SHORT_HDR;
    else if (!strm.magic_ok) v.status = ST_BAD_MAGIC;
    else if (strm.version != cfg_version) v.status = ST_BAD_VERSION;
    else if (strm.dsize > plen) v.status = ST_SHORT_PAYLOAD;
    else if (strm.dsize != plen) v.status = ST_SIZE_MISMATCH;
    else if (cfg_verify && strm.hash != strm.csum) v.status = ST_CSUM_MISMATCH;
    else v.status = ST_OK;
    v.hash   = strm.hash;
    v.length = plen;
    restart_stream();
    return 1'b1;
  endfunction

  task automatic put_byte(input logic [7:0] b, input logic last, output bit got,
                          output file_verdict_t v);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      byte_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    byte_bus.valid      <= 1'b1;
    byte_bus.byte_value <= b;
    byte_bus.last_byte  <= last;
    do @(posedge clk_i); while (!byte_bus.ready);
    bytes_sent++;
    got = fold_byte(b, last, v);
  endtask

  // header checksum is (good ? payload hash : 0) ^ csum
  task automatic send_file(input logic [4:0] take, input logic [4:0] flip_at,
                           input logic [31:0] ver, input logic [63:0] dsize,
                           input logic good_csum, input logic [63:0] csum,
                           input logic [7:0] plen, input logic typed, input cfh_status_e st);
    logic [7:0]    hdr [28];
    logic [7:0]    body [256];
    logic [63:0]   h;
    logic [63:0]   sum;
    file_verdict_t v;
    bit            got;
    int unsigned   i;
    h = OFFSET_BASIS;
    for (i = 0; i < plen; i++) begin
      body[i] = 8'($urandom);
      h = fnv_round(h, body[i]);
    end
    sum = (good_csum ? h : 64'd0) ^ csum;
    for (i = 0; i < 8; i++) begin
      hdr[i]      = HDR_MAGIC[i];
      hdr[12 + i] = dsize[8*i +: 8];
      hdr[20 + i] = sum[8*i +: 8];
    end
    for (i = 0; i < 4; i++) hdr[8 + i] = ver[8*i +: 8];
    if (flip_at < 5'd28) hdr[flip_at] = hdr[flip_at] ^ 8'($urandom_range(1, 255));
    for (i = 0; i < take; i++) begin
      put_byte(hdr[i], (i == take - 1) && (take < 5'd28 || plen == 0), got, v);
    end
    if (take == 5'd28) begin
      for (i = 0; i < plen; i++) put_byte(body[i], i == plen - 1, got, v);
    end
    if (typed) v = '{st, OFFSET_BASIS, 64'd0};
    if (got) begin
      queue_verdict(v);
    end
  endtask

  task automatic drain_results();
    byte_bus.valid <= 1'b0;
    while (file_verdicts.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic configure(input logic [31:0] ver, input logic [31:0] verify_word);
    logic [1:0]  idx [3];
    logic [31:0] val [3];
    int          i;
    idx[0] = CFG_EXP_VERSION;
    val[0] = ver;
    idx[1] = ($urandom_range(0, 1) == 0) ? CFG_SPARE_A : CFG_SPARE_B;
    val[1] = $urandom;
    idx[2] = CFG_VERIFY;
    val[2] = verify_word;
    for (i = 0; i < 3; i++) begin
      cfg_bus.valid <= 1'b1;
      cfg_bus.index <= idx[i];
      cfg_bus.data  <= val[i];
      do @(posedge clk_i); while (!cfg_bus.ready);
      case (idx[i])
        CFG_EXP_VERSION: cfg_version = val[i];
        CFG_VERIFY:      cfg_verify  = val[i][0];
        default: ;
      endcase
    end
    cfg_bus.valid <= 1'b0;
  endtask

  always @(posedge clk_i) begin
    file_verdict_t exp_v;
    if (rst_ni && result_bus.valid && result_bus.ready) begin
      if (file_verdicts.size() == 0) begin
        errors++;
        $display("%0t: unexpected result status %0d hash %h length %0d", $time,
                 result_bus.status, result_bus.payload_hash, result_bus.payload_length);
      end else begin
        exp_v = file_verdicts.pop_front();
        if (result_bus.status !== exp_v.status) begin
          errors++;
          $display("%0t: status expected %0d got %0d", $time, exp_v.status,
                   result_bus.status);
        end
        if (result_bus.payload_hash !== exp_v.hash) begin
          errors++;
          $display("%0t: payload_hash expected %h got %h", $time, exp_v.hash,
                   result_bus.payload_hash);
        end
        if (result_bus.payload_length !== exp_v.length) begin
          errors++;
          $display("%0t: payload_length expected %0d got %0d", $time, exp_v.length,
                   result_bus.payload_length);
        end
      end
    end
  end

  initial begin
    int          rand_start;
    int          rand_files;
    int          kind;
    int          n;
    int          i;
    logic [4:0]  take;
    logic [4:0]  flip_at;
    logic [31:0] ver;
    logic [63:0] dsize;
    logic [63:0] csum;
    logic [7:0]  plen;
    logic [31:0] new_ver;
    bit          got;
    file_verdict_t v;

    rst_ni              <= 1'b0;
    byte_bus.valid      <= 1'b0;
    byte_bus.byte_value <= '0;
    byte_bus.last_byte  <= 1'b0;
    cfg_bus.valid       <= 1'b0;
    cfg_bus.index       <= '0;
    cfg_bus.data        <= '0;
    cfg_version = '0;
    cfg_verify  = 1'b1;
    restart_stream();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    for (i = 0; i < NUM_ROWS; i++) begin
      if (FILE_ROWS[i].set_cfg) begin
        drain_results();
        configure(FILE_ROWS[i].cfg_ver, FILE_ROWS[i].cfg_verify);
      end
      send_file(FILE_ROWS[i].take, FILE_ROWS[i].flip_at, FILE_ROWS[i].ver,
                FILE_ROWS[i].dsize, FILE_ROWS[i].good_csum, FILE_ROWS[i].csum,
                FILE_ROWS[i].plen, FILE_ROWS[i].typed, FILE_ROWS[i].st);
    end

    rand_start = bytes_sent;
    rand_files = 0;
    while (bytes_sent < rand_start + RAND_BYTES || rand_files < RAND_FILES) begin
      if (bytes_sent < 520) begin
        tx_idle_pct = 19;
        rx_idle_pct = 54;
      end else if (bytes_sent < 1040) begin
        tx_idle_pct = 54;
        rx_idle_pct = 19;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end

      kind    = $urandom_range(0, 99);
      plen    = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(13, 120))
                                            : 8'($urandom_range(0, 12));
      take    = 5'd28;
      flip_at = NO_FLIP;
      ver     = cfg_version;
      dsize   = {56'd0, plen};
      csum    = '0;
      if (kind < 62) begin
        // well-formed file
      end else if (kind < 70) begin
        take = 5'($urandom_range(1, 27));
        if ($urandom_range(0, 1) == 0) flip_at = 5'($urandom_range(0, 27));
      end else if (kind < 76) begin
        flip_at = 5'($urandom_range(0, 7));
      end else if (kind < 82) begin
        ver = cfg_version ^ (32'd1 << $urandom_range(0, 31));
      end else if (kind < 88) begin
        case ($urandom_range(0, 2))
          0: dsize = dsize + 64'($urandom_range(1, 3));
          1: dsize = dsize - 64'd1;
          default: dsize = {$urandom, $urandom};
        endcase
      end else if (kind < 94) begin
        csum = 64'd1 << $urandom_range(0, 63);
      end

      if (kind >= 94) begin
        // raw noise with no header structure
        n = $urandom_range(1, 40);
        for (i = 0; i < n; i++) put_byte(8'($urandom), i == n - 1, got, v);
        queue_verdict(v);
      end else begin
        send_file(take, flip_at, ver, dsize, 1'b1, csum, plen, 1'b0, ST_OK);
      end
      rand_files++;

      if ($urandom_range(0, 5) == 0) begin
        case ($urandom_range(0, 4))
          0: new_ver = '0;
          1: new_ver = '1;
          default: new_ver = $urandom;
        endcase
        drain_results();
        configure(new_ver, $urandom);
      end
    end

    drain_results();
    if (errors == 0 && file_verdicts.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

`default_nettype wire
